// ===== hdl/block_framer_2bit_symbol_sender_assert.svh =====
// Assertion macros for the block framer symbol sender.
`ifndef BLOCK_FRAMER_2BIT_SYMBOL_SENDER_ASSERT_SVH
`define BLOCK_FRAMER_2BIT_SYMBOL_SENDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FSB_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("framer assertion failed");

// Next-cycle implication, checked outside reset.
`define FSB_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("framer assertion failed");

`endif

// ===== hdl/fsb_pkg.sv =====
// Types, constants and helper functions shared by the framer modules.
`timescale 1ns / 1ps

package fsb_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam int IDX_W = $clog2(BLOCK_BYTES);
  localparam int CNT_W = $clog2(BLOCK_BYTES + 1);

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_END  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] CFG_START    = 2'd0;
  localparam logic [1:0] CFG_LAST     = 2'd1;
  localparam logic [1:0] CFG_CHECKSUM = 2'd2;
  localparam logic [1:0] CFG_END      = 2'd3;

  localparam logic [2:0] RST_START_SYM    = 3'd1;
  localparam logic [2:0] RST_LAST_SYM     = 3'd1;
  localparam logic [2:0] RST_CHECKSUM_SYM = 3'd2;
  localparam logic [2:0] RST_END_SYM      = 3'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       symbol_valid;
    logic [2:0] symbol;
    logic       stream_done;
  } result_t;

  typedef struct packed {
    logic [2:0] start_symbol;
    logic [2:0] last_block_symbol;
    logic [2:0] checksum_marker;
    logic [2:0] end_symbol;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [IDX_W-1:0] raddr;
  } store_req_t;

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_LAST     = 9'b000000010,
    PH_START    = 9'b000000100,
    PH_DATA     = 9'b000001000,
    PH_CSMARK   = 9'b000010000,
    PH_CSDATA   = 9'b000100000,
    PH_ENDFRAME = 9'b001000000,
    PH_CLOSE1   = 9'b010000000,
    PH_CLOSE2   = 9'b100000000
  } phase_t;

  // Line symbol for one 2-bit group, MSB group first, clock bit set.
  function automatic logic [2:0] group_symbol(input logic [7:0] b, input logic [1:0] g);
    logic [1:0] pair;
    case (g)
      2'd0:    pair = b[7:6];
      2'd1:    pair = b[5:4];
      2'd2:    pair = b[3:2];
      default: pair = b[1:0];
    endcase
    return {1'b1, pair};
  endfunction

  function automatic logic [3:0] bits_set(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, b[i]};
    end
    return n;
  endfunction

endpackage

// ===== hdl/block_framer_2bit_symbol_sender.sv =====
// Block framer and 3-bit line symbol sender, top level.
// A taken request is executed in the next cycle, while pending is high; its result
// is registered into result and strobes on done for one cycle.
// While busy, no new request is taken; this paces the store's registered read.
// Reset (synchronous rst): phase idle, counts cleared, symbol registers to defaults;
// store contents are left as they are. The receiver cannot stall results.
`timescale 1ns / 1ps
`include "block_framer_2bit_symbol_sender_assert.svh"

module block_framer_2bit_symbol_sender (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  fsb_pkg::item_t   item,
  output logic             done,
  output fsb_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [2:0]       cfg_data
);
  import fsb_pkg::*;

  logic       pending;
  item_t      item_q;
  cfg_t       cfg;
  store_req_t req;
  logic [7:0] rdata;
  result_t    res;

  assign busy      = pending;
  assign cfg_ready = 1'b1;

  fsb_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  fsb_framer u_framer (
    .clk   (clk),
    .rst   (rst),
    .exec  (pending),
    .item  (item_q),
    .cfg   (cfg),
    .rdata (rdata),
    .req   (req),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_symbol      <= RST_START_SYM;
      cfg.last_block_symbol <= RST_LAST_SYM;
      cfg.checksum_marker   <= RST_CHECKSUM_SYM;
      cfg.end_symbol        <= RST_END_SYM;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START:    cfg.start_symbol      <= cfg_data;
        CFG_LAST:     cfg.last_block_symbol <= cfg_data;
        CFG_CHECKSUM: cfg.checksum_marker   <= cfg_data;
        CFG_END:      cfg.end_symbol        <= cfg_data;
        default:      cfg.end_symbol        <= cfg.end_symbol;
      endcase
    end
  end

  // Hold the request for its execution cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      done    <= 1'b0;
    end else begin
      pending <= start && !pending;
      done    <= pending;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !pending) begin
      item_q <= item;
    end
    if (pending) begin
      result <= res;
    end
  end

  `FSB_ASSERT_NEXT(a_busy_single, busy, !busy && done)
  `FSB_ASSERT_NOW(a_done_after_busy, done, $past(busy))
  `FSB_ASSERT_NOW(a_done_has_symbol, done && result.stream_done, result.symbol_valid)
  `FSB_ASSERT_NOW(a_acc_or_sym, done, !(result.accepted && result.symbol_valid))

endmodule

// ===== hdl/fsb_store.sv =====
// Block store: one write port and one registered read port.
`timescale 1ns / 1ps

module fsb_store (
  input  logic                clk,
  input  fsb_pkg::store_req_t req,
  output logic [7:0]          rdata
);
  import fsb_pkg::*;

  logic [7:0] mem [BLOCK_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== hdl/fsb_framer.sv =====
// Framing sequencer: collects bytes into the store and walks the frame symbols.
`timescale 1ns / 1ps

module fsb_framer (
  input  logic                clk,
  input  logic                rst,
  input  logic                exec,
  input  fsb_pkg::item_t      item,
  input  fsb_pkg::cfg_t       cfg,
  input  logic [7:0]          rdata,
  output fsb_pkg::store_req_t req,
  output fsb_pkg::result_t    res
);
  import fsb_pkg::*;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [7:0]       popcount_sum, popcount_sum_next;
  logic [IDX_W-1:0] send_byte_index, send_byte_index_next;
  logic [1:0]       group_index, group_index_next;
  logic             final_block_flag, final_block_flag_next;
  logic             full_block_waiting, full_block_waiting_next;

  logic [CNT_W-1:0] fill_inc;
  logic [CNT_W-1:0] idx_inc;

  assign fill_inc = fill_count + CNT_W'(1);
  assign idx_inc  = {1'b0, send_byte_index} + CNT_W'(1);

  always_comb begin
    phase_next              = phase;
    fill_count_next         = fill_count;
    popcount_sum_next       = popcount_sum;
    send_byte_index_next    = send_byte_index;
    group_index_next        = group_index;
    final_block_flag_next   = final_block_flag;
    full_block_waiting_next = full_block_waiting;
    // The read is issued in the request cycle, so the byte is ready for execution.
    req.raddr               = send_byte_index;
    req.waddr               = fill_count[IDX_W-1:0];
    req.wdata               = item.data_byte;
    req.we                  = 1'b0;
    res                     = '0;

    if (exec) begin
      case (item.opcode)
        OP_PUSH: begin
          if (phase == PH_IDLE && !full_block_waiting &&
              fill_count < CNT_W'(BLOCK_BYTES)) begin
            req.we            = 1'b1;
            fill_count_next   = fill_inc;
            popcount_sum_next = popcount_sum + {4'd0, bits_set(item.data_byte)};
            if (fill_inc >= CNT_W'(BLOCK_BYTES)) begin
              full_block_waiting_next = 1'b1;
            end
            res.accepted = 1'b1;
          end
        end
        OP_END: begin
          if (phase == PH_IDLE) begin
            res.accepted            = 1'b1;
            full_block_waiting_next = 1'b0;
            if (fill_count != '0) begin
              final_block_flag_next = 1'b1;
              phase_next            = PH_LAST;
            end else begin
              phase_next = PH_CLOSE1;
            end
          end
        end
        OP_TICK: begin
          case (phase)
            PH_IDLE: begin
              // A full block goes out as a non-final frame.
              if (full_block_waiting) begin
                full_block_waiting_next = 1'b0;
                res.symbol_valid        = 1'b1;
                res.symbol              = cfg.start_symbol;
                phase_next              = PH_DATA;
                send_byte_index_next    = '0;
                group_index_next        = '0;
              end
            end
            PH_LAST: begin
              res.symbol_valid = 1'b1;
              res.symbol       = cfg.last_block_symbol;
              phase_next       = PH_START;
            end
            PH_START: begin
              res.symbol_valid     = 1'b1;
              res.symbol           = cfg.start_symbol;
              phase_next           = PH_DATA;
              send_byte_index_next = '0;
              group_index_next     = '0;
            end
            PH_DATA: begin
              res.symbol_valid = 1'b1;
              res.symbol       = group_symbol(rdata, group_index);
              if (group_index == 2'd3) begin
                group_index_next     = '0;
                send_byte_index_next = idx_inc[IDX_W-1:0];
                if (idx_inc >= fill_count) begin
                  phase_next = PH_CSMARK;
                end
              end else begin
                group_index_next = group_index + 2'd1;
              end
            end
            PH_CSMARK: begin
              res.symbol_valid = 1'b1;
              res.symbol       = cfg.checksum_marker;
              phase_next       = PH_CSDATA;
              group_index_next = '0;
            end
            PH_CSDATA: begin
              res.symbol_valid = 1'b1;
              res.symbol       = group_symbol(popcount_sum, group_index);
              if (group_index == 2'd3) begin
                group_index_next = '0;
                phase_next       = PH_ENDFRAME;
              end else begin
                group_index_next = group_index + 2'd1;
              end
            end
            PH_ENDFRAME: begin
              res.symbol_valid     = 1'b1;
              res.symbol           = cfg.end_symbol;
              fill_count_next      = '0;
              popcount_sum_next    = '0;
              send_byte_index_next = '0;
              phase_next           = final_block_flag ? PH_CLOSE1 : PH_IDLE;
            end
            PH_CLOSE1: begin
              res.symbol_valid = 1'b1;
              res.symbol       = cfg.end_symbol;
              phase_next       = PH_CLOSE2;
            end
            PH_CLOSE2: begin
              res.symbol_valid      = 1'b1;
              res.symbol            = cfg.end_symbol;
              res.stream_done       = 1'b1;
              final_block_flag_next = 1'b0;
              phase_next            = PH_IDLE;
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
        default: begin
          // unknown opcode: leave everything as it is
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      fill_count         <= '0;
      popcount_sum       <= '0;
      send_byte_index    <= '0;
      group_index        <= '0;
      final_block_flag   <= 1'b0;
      full_block_waiting <= 1'b0;
    end else begin
      phase              <= phase_next;
      fill_count         <= fill_count_next;
      popcount_sum       <= popcount_sum_next;
      send_byte_index    <= send_byte_index_next;
      group_index        <= group_index_next;
      final_block_flag   <= final_block_flag_next;
      full_block_waiting <= full_block_waiting_next;
    end
  end

endmodule
